@@ hdl/ipdq_pkg.sv @@
// Shared types, codes and constants for the modem frame demux queue.
`default_nettype none
package ipdq_pkg;

  localparam int LinksDefault      = 5;
  localparam int MaxPayloadDefault = 1024;
  localparam int QueueSlotsDefault = 2;

  localparam int HdrLen = 5;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [19:0] LenSat = 20'd65535;

  // Item kinds (also used for result kinds)
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_TAKE = 2'd2;

  // Reply status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_PKT   = 3'd1;
  localparam logic [2:0] ST_TOO_BIG  = 3'd2;
  localparam logic [2:0] ST_BAD_LINK = 3'd3;
  localparam logic [2:0] ST_BAD_OFF  = 3'd4;

  typedef enum logic [4:0] {
    MODE_TEXT    = 5'b00001,
    MODE_LINK    = 5'b00010,
    MODE_LENGTH  = 5'b00100,
    MODE_PAYLOAD = 5'b01000,
    MODE_SKIP    = 5'b10000
  } mode_t;

  // Transaction held in the reply stage
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  text_n;   // released prefix bytes
    logic        emit_b;   // received byte itself goes out as text
    logic [7:0]  rx_byte;
    logic [2:0]  pre_st;   // bad link / empty queue found up front
    logic [3:0]  link;
    logic        off_hi;   // offset at or beyond the slot size
    logic [10:0] off;
    logic [15:0] cap;
    logic [31:0] drops;
  } s2_t;

  typedef struct packed {
    logic       pop;
    logic [3:0] link;
  } pop_t;

  typedef struct packed {
    logic free;      // reply stage can take a new transaction this cycle
    logic take_blk;  // a take is pending, queue pointers not settled
  } s2_stat_t;

  function automatic logic [7:0] hdr_char(input logic [2:0] i);
    case (i)
      3'd0:    hdr_char = ChPlus;
      3'd1:    hdr_char = 8'h49;
      3'd2:    hdr_char = 8'h50;
      3'd3:    hdr_char = 8'h44;
      3'd4:    hdr_char = ChComma;
      default: hdr_char = 8'h00;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ hdl/ipdq_ram.sv @@
// Single-port synchronous RAM with registered read data.
`default_nettype none
module ipdq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end
endmodule
`default_nettype wire

@@ hdl/ipdq_out.sv @@
// Reply stage: forms results from RAM read data and feeds the output register.
`default_nettype none
module ipdq_out (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire ipdq_pkg::s2_t     s2_in,
  input  wire logic [7:0]        rd_byte,
  input  wire logic [11:0]       rd_len,
  output ipdq_pkg::s2_stat_t     stat,
  output ipdq_pkg::pop_t         pop,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [1:0]             result_kind,
  output logic [7:0]             data_byte,
  output logic [2:0]             status,
  output logic [11:0]            packet_length,
  output logic                   last,
  output logic [31:0]            dropped_count
);
  import ipdq_pkg::*;

  logic       s2_valid;
  s2_t        s2;
  logic [2:0] idx;
  logic       advance;
  logic       is_last;
  logic [2:0] total;
  logic [1:0] r_kind;
  logic [7:0] r_data;
  logic [2:0] r_st;
  logic [11:0] r_len;

  assign advance = s2_valid && (!out_valid || out_ready);
  assign total   = (s2.kind == KIND_BYTE) ? s2.text_n + {2'b00, s2.emit_b} : 3'd1;
  assign is_last = (idx == total - 3'd1);

  assign stat.free     = !s2_valid || (advance && is_last);
  assign stat.take_blk = s2_valid && (s2.kind == KIND_TAKE);

  // Result for the current position
  always_comb begin
    r_kind   = s2.kind;
    r_data   = 8'h00;
    r_st     = ST_OK;
    r_len    = 12'd0;
    pop.pop  = 1'b0;
    pop.link = s2.link;
    if (s2.kind == KIND_BYTE) begin
      r_data = (idx < s2.text_n) ? hdr_char(idx) : s2.rx_byte;
    end else if (s2.pre_st != ST_OK) begin
      r_st = s2.pre_st;
    end else if (s2.kind == KIND_READ) begin
      r_len = rd_len;
      if (s2.off_hi || ({1'b0, s2.off} >= rd_len)) begin
        r_st = ST_BAD_OFF;
      end else begin
        r_data = rd_byte;
      end
    end else begin
      r_len = rd_len;
      if ({4'd0, rd_len} > s2.cap) begin
        r_st = ST_TOO_BIG;
      end else begin
        pop.pop = advance;
      end
    end
  end

  // Stage register and result index
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      idx      <= 3'd0;
    end else begin
      if (advance) begin
        idx <= idx + 3'd1;
      end
      if (stat.free) begin
        s2_valid <= load;
        idx      <= 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stat.free && load) begin
      s2 <= s2_in;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_kind   <= r_kind;
      data_byte     <= r_data;
      status        <= r_st;
      packet_length <= r_len;
      last          <= is_last;
      dropped_count <= s2.drops;
    end
  end
endmodule
`default_nettype wire

@@ hdl/ipd_frame_demux_queue.sv @@
// Top level: frame parser, per-link slot rings, payload and length RAMs.
// A result is registered in the reply stage, then in the output register;
// a prefix flush gives up to five results, one per cycle unless the output stalls,
// and holds input meanwhile. Throughput: one item per cycle unless output stalls;
// a take item holds input while its pop is settled from the length RAM read.
// Reset: rst (synchronous) clears parser state, ring pointers and drop count;
// RAM contents are not cleared.
`default_nettype none
module ipd_frame_demux_queue #(
  parameter int LINKS       = ipdq_pkg::LinksDefault,
  parameter int MAX_PAYLOAD = ipdq_pkg::MaxPayloadDefault,
  parameter int QUEUE_SLOTS = ipdq_pkg::QueueSlotsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [3:0]  link_select,
  input  wire logic [10:0] byte_offset,
  input  wire logic [15:0] caller_capacity,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       result_kind,
  output logic [7:0]       data_byte,
  output logic [2:0]       status,
  output logic [11:0]      packet_length,
  output logic             last,
  output logic [31:0]      dropped_count
);
  import ipdq_pkg::*;

  localparam int NSLOT   = LINKS * QUEUE_SLOTS;
  localparam int PDEPTH  = NSLOT * MAX_PAYLOAD;
  localparam int LINK_W  = (LINKS > 1) ? $clog2(LINKS) : 1;
  localparam int SLOT_W  = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int FILL_W  = $clog2(QUEUE_SLOTS + 1);
  localparam int LAW     = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int PAW     = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
  localparam int OFF_W   = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  // Parser state
  mode_t       mode, mode_next;
  logic [2:0]  pmatch, pmatch_next;
  logic [3:0]  flink, flink_next;
  logic [15:0] flen, flen_next;
  logic [15:0] seen, seen_next;
  logic [31:0] drops, drops_next;

  // Ring pointers per link
  logic [SLOT_W-1:0] head [LINKS];
  logic [SLOT_W-1:0] tail [LINKS];
  logic [FILL_W-1:0] fill [LINKS];

  s2_stat_t st2;
  pop_t     pop;
  s2_t      s2_in;
  logic     load;
  logic     acc;

  logic [LINK_W-1:0] fl_idx, sel_idx, pop_idx;
  logic              sel_ok;
  logic              is_digit;
  logic [3:0]        digit;
  logic [19:0]       len_acc;
  logic [16:0]       seen_inc;
  logic              push;

  logic           len_en, len_we;
  logic [LAW-1:0] len_addr;
  logic [11:0]    len_wdata, len_rdata;
  logic           pay_en, pay_we;
  logic [PAW-1:0] pay_addr;
  logic [7:0]     pay_rdata;

  assign in_ready = st2.free && !st2.take_blk;
  assign acc      = in_valid && in_ready;

  assign fl_idx   = flink[LINK_W-1:0];
  assign sel_idx  = link_select[LINK_W-1:0];
  assign pop_idx  = pop.link[LINK_W-1:0];
  assign sel_ok   = ({28'd0, link_select} < LINKS);
  assign is_digit = (rx_byte >= ChZero) && (rx_byte <= ChNine);
  assign digit    = 4'(rx_byte - ChZero);
  assign len_acc  = {4'd0, flen} * 20'd10 + {16'd0, digit};
  assign seen_inc = {1'b0, seen} + 17'd1;

  // Parser and request issue for the current transaction
  always_comb begin
    mode_next   = mode;
    pmatch_next = pmatch;
    flink_next  = flink;
    flen_next   = flen;
    seen_next   = seen;
    drops_next  = drops;
    push        = 1'b0;
    load        = 1'b0;
    len_en      = 1'b0;
    len_we      = 1'b0;
    len_addr    = LAW'(fl_idx * QUEUE_SLOTS + tail[fl_idx]);
    len_wdata   = flen[11:0];
    pay_en      = 1'b0;
    pay_we      = 1'b0;
    pay_addr    = PAW'((fl_idx * QUEUE_SLOTS + tail[fl_idx]) * MAX_PAYLOAD + seen);
    s2_in.kind    = kind;
    s2_in.text_n  = 3'd0;
    s2_in.emit_b  = 1'b0;
    s2_in.rx_byte = rx_byte;
    s2_in.pre_st  = ST_OK;
    s2_in.link    = link_select;
    s2_in.off_hi  = ({21'd0, byte_offset} >= MAX_PAYLOAD);
    s2_in.off     = byte_offset;
    s2_in.cap     = caller_capacity;

    if (acc && kind == KIND_BYTE) begin
      case (mode)
        MODE_TEXT: begin
          if ((pmatch < 3'(HdrLen)) && (rx_byte == hdr_char(pmatch))) begin
            if (pmatch == 3'(HdrLen - 1)) begin
              pmatch_next = 3'd0;
              mode_next   = MODE_LINK;
              flink_next  = 4'd0;
            end else begin
              pmatch_next = pmatch + 3'd1;
            end
          end else begin
            s2_in.text_n = pmatch;
            s2_in.emit_b = (rx_byte != ChPlus);
            pmatch_next  = (rx_byte == ChPlus) ? 3'd1 : 3'd0;
            load         = (pmatch != 3'd0) || (rx_byte != ChPlus);
          end
        end
        MODE_LINK: begin
          if (is_digit) begin
            flink_next = digit;
          end else if (rx_byte == ChComma && ({28'd0, flink} < LINKS)) begin
            flen_next = 16'd0;
            mode_next = MODE_LENGTH;
          end else begin
            drops_next = drops + 32'd1;
            mode_next  = MODE_TEXT;
            flink_next = 4'd0;
            flen_next  = 16'd0;
            seen_next  = 16'd0;
          end
        end
        MODE_LENGTH: begin
          if (is_digit) begin
            flen_next = (len_acc > LenSat) ? 16'hFFFF : len_acc[15:0];
          end else if (rx_byte == ChColon && flen != 16'd0) begin
            seen_next = 16'd0;
            if (({28'd0, flink} >= LINKS) || ({16'd0, flen} > MAX_PAYLOAD) ||
                ({{(32-FILL_W){1'b0}}, fill[fl_idx]} >= QUEUE_SLOTS)) begin
              drops_next = drops + 32'd1;
              mode_next  = MODE_SKIP;
            end else begin
              len_en    = 1'b1;
              len_we    = 1'b1;
              mode_next = MODE_PAYLOAD;
            end
          end else begin
            // bad character or zero length
            drops_next = drops + 32'd1;
            mode_next  = MODE_TEXT;
            flink_next = 4'd0;
            flen_next  = 16'd0;
            seen_next  = 16'd0;
          end
        end
        MODE_PAYLOAD: begin
          pay_en    = ({16'd0, seen} < MAX_PAYLOAD);
          pay_we    = 1'b1;
          seen_next = seen_inc[15:0];
          if (seen_inc >= {1'b0, flen}) begin
            push       = 1'b1;
            mode_next  = MODE_TEXT;
            flink_next = 4'd0;
            flen_next  = 16'd0;
            seen_next  = 16'd0;
          end
        end
        MODE_SKIP: begin
          seen_next = seen_inc[15:0];
          if (seen_inc >= {1'b0, flen}) begin
            mode_next  = MODE_TEXT;
            flink_next = 4'd0;
            flen_next  = 16'd0;
            seen_next  = 16'd0;
          end
        end
        default: begin
          drops_next = drops + 32'd1;
          mode_next  = MODE_TEXT;
          flink_next = 4'd0;
          flen_next  = 16'd0;
          seen_next  = 16'd0;
        end
      endcase
    end else if (acc && (kind == KIND_READ || kind == KIND_TAKE)) begin
      load = 1'b1;
      if (!sel_ok) begin
        s2_in.pre_st = ST_BAD_LINK;
      end else if (fill[sel_idx] == '0) begin
        s2_in.pre_st = ST_NO_PKT;
      end else begin
        len_en   = 1'b1;
        len_addr = LAW'(sel_idx * QUEUE_SLOTS + head[sel_idx]);
        pay_en   = (kind == KIND_READ);
        pay_addr = PAW'((sel_idx * QUEUE_SLOTS + head[sel_idx]) * MAX_PAYLOAD +
                        byte_offset[OFF_W-1:0]);
      end
    end
    s2_in.drops = drops_next;
  end

  // Parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_TEXT;
      pmatch <= 3'd0;
      flink  <= 4'd0;
      flen   <= 16'd0;
      seen   <= 16'd0;
      drops  <= 32'd0;
    end else begin
      mode   <= mode_next;
      pmatch <= pmatch_next;
      flink  <= flink_next;
      flen   <= flen_next;
      seen   <= seen_next;
      drops  <= drops_next;
    end
  end

  // Ring pointers: push from the parser, pop from the reply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LINKS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      if (push) begin
        tail[fl_idx] <= ({{(32-SLOT_W){1'b0}}, tail[fl_idx]} + 1 >= QUEUE_SLOTS) ?
                        '0 : tail[fl_idx] + 1'b1;
        fill[fl_idx] <= fill[fl_idx] + 1'b1;
      end
      if (pop.pop) begin
        head[pop_idx] <= ({{(32-SLOT_W){1'b0}}, head[pop_idx]} + 1 >= QUEUE_SLOTS) ?
                         '0 : head[pop_idx] + 1'b1;
        fill[pop_idx] <= fill[pop_idx] - 1'b1;
      end
    end
  end

  ipdq_ram #(.DEPTH(NSLOT), .WIDTH(12), .AW(LAW)) u_len_ram (
    .clk   (clk),
    .en    (len_en),
    .we    (len_we),
    .addr  (len_addr),
    .wdata (len_wdata),
    .rdata (len_rdata)
  );

  ipdq_ram #(.DEPTH(PDEPTH), .WIDTH(8), .AW(PAW)) u_pay_ram (
    .clk   (clk),
    .en    (pay_en),
    .we    (pay_we),
    .addr  (pay_addr),
    .wdata (rx_byte),
    .rdata (pay_rdata)
  );

  ipdq_out u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .s2_in         (s2_in),
    .rd_byte       (pay_rdata),
    .rd_len        (len_rdata),
    .stat          (st2),
    .pop           (pop),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .result_kind   (result_kind),
    .data_byte     (data_byte),
    .status        (status),
    .packet_length (packet_length),
    .last          (last),
    .dropped_count (dropped_count)
  );
endmodule
`default_nettype wire
